### src/generation_checked_slot_pool_defines.svh
// Assertion macros used by the checker file of the slot pool.
`ifndef GENERATION_CHECKED_SLOT_POOL_DEFINES_SVH
`define GENERATION_CHECKED_SLOT_POOL_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define GCSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("slot pool check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define GCSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("slot pool check failed");

`endif

### src/gcsp_pkg.sv
// Shared types, constants and control structs of the slot pool.
`timescale 1ns / 1ps
`default_nettype none
package gcsp_pkg;

    localparam int SLOT_COUNT_DEF  = 8;
    localparam int HANDLE_REGS_DEF = 8;

    localparam int ARG_W    = 8;
    localparam int DATA_W   = 8;
    localparam int GEN_W    = 32;
    localparam int CNT_W    = 32;
    localparam int VALUE_W  = 35;
    localparam int FOLD_W   = 64;
    localparam int GEN_SHIFT  = 3;   // generation weight of 8 in the alloc value
    localparam int FOLD_SHIFT = 5;   // x*31 = (x << 5) - x

    localparam logic [VALUE_W-1:0] REJECT_VALUE = VALUE_W'(251);
    localparam logic [VALUE_W-1:0] FREE_VALUE   = VALUE_W'(1);
    localparam logic [VALUE_W-1:0] WRITE_VALUE  = VALUE_W'(3);

    localparam logic [DATA_W-1:0] ALLOC_MUL = DATA_W'(7);
    localparam logic [DATA_W-1:0] ALLOC_ADD = DATA_W'(1);
    localparam logic [DATA_W-1:0] WRITE_MUL = DATA_W'(13);
    localparam logic [DATA_W-1:0] WRITE_ADD = DATA_W'(3);

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_WRITE = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [ARG_W-1:0]  arg_byte;
        logic              restart;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               rejected;
        logic [FOLD_W-1:0]  running_fold;
        logic [FOLD_W-1:0]  digest;
    } out_word_t;

    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic rd_handle;  // read handle register
        logic rd_slot;    // read slot state
        logic update;     // apply operation, fold
        logic mul;        // fold * 31
        logic load_out;   // load output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;   // output register can take a word
    } ctrl_sts_t;

endpackage
`default_nettype wire

### src/generation_checked_slot_pool.sv
// The sequencer walks handle read, slot read, update, fold multiply and digest for
//   one word before it takes the next; the result word is loaded in the digest step.
// A waiting result stalls the digest step only, and leaves m_data stable.
// Reset: aresetn (sync, active low) empties all handles and rebuilds the free list
//   at once via valid bits; a restart word does the same on its accept cycle.
`timescale 1ns / 1ps
`default_nettype none
module generation_checked_slot_pool #(
    parameter int SLOT_COUNT  = gcsp_pkg::SLOT_COUNT_DEF,
    parameter int HANDLE_REGS = gcsp_pkg::HANDLE_REGS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // operation words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gcsp_pkg::in_word_t   s_data,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output gcsp_pkg::out_word_t  m_data
);
    import gcsp_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer: one-hot FSM, one word in flight.
    gcsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: slot stores are small memories with registered reads; generation
    // and link entries carry valid bits so a restart costs no clearing pass.
    // Fold and digest each take one shift-subtract (x*31) and one add per step.
    gcsp_dpath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .HANDLE_REGS (HANDLE_REGS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

### src/gcsp_ctrl.sv
// Sequencer of the slot pool: steps one word through the datapath phases.
`timescale 1ns / 1ps
`default_nettype none
module gcsp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gcsp_pkg::ctrl_sts_t   sts,
    output gcsp_pkg::ctrl_cmd_t   cmd
);
    import gcsp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RDH  = 6'b000010,
        ST_RDS  = 6'b000100,
        ST_UPD  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_DIG  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_RDH;
            end
            ST_RDH: state_next = ST_RDS;
            ST_RDS: state_next = ST_UPD;
            ST_UPD: state_next = ST_MUL;
            ST_MUL: state_next = ST_DIG;
            ST_DIG: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign cmd.accept    = s_valid && s_ready;
    assign cmd.rd_handle = (state_reg == ST_RDH);
    assign cmd.rd_slot   = (state_reg == ST_RDS);
    assign cmd.update    = (state_reg == ST_UPD);
    assign cmd.mul       = (state_reg == ST_MUL);
    assign cmd.load_out  = (state_reg == ST_DIG) && sts.out_free;

endmodule
`default_nettype wire

### src/gcsp_dpath.sv
// Datapath of the slot pool: slot and handle stores, free list, fold and digest.
`timescale 1ns / 1ps
`default_nettype none
module gcsp_dpath #(
    parameter int SLOT_COUNT  = gcsp_pkg::SLOT_COUNT_DEF,
    parameter int HANDLE_REGS = gcsp_pkg::HANDLE_REGS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gcsp_pkg::in_word_t    s_data,
    input  gcsp_pkg::ctrl_cmd_t   cmd,
    output gcsp_pkg::ctrl_sts_t   sts,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gcsp_pkg::out_word_t   m_data
);
    import gcsp_pkg::*;

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int REG_W     = (HANDLE_REGS > 1) ? $clog2(HANDLE_REGS) : 1;
    localparam int ARG_DEPTH = 2 ** ARG_W;
    localparam int HND_W     = SLOT_W + GEN_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // arg mod HANDLE_REGS as a constant lookup
    logic [REG_W-1:0] reg_tab [ARG_DEPTH];
    for (genvar i = 0; i < ARG_DEPTH; i++) begin : g_reg_tab
        assign reg_tab[i] = REG_W'(i % HANDLE_REGS);
    end

    // stores
    logic [DATA_W-1:0] data_mem   [SLOT_COUNT];
    logic [GEN_W-1:0]  gen_mem    [SLOT_COUNT];
    logic [SLOT_W:0]   link_mem   [SLOT_COUNT];   // {successor valid, successor}
    logic [HND_W-1:0]  handle_mem [HANDLE_REGS];  // {slot, generation}

    logic [SLOT_COUNT-1:0]  gen_vld_reg;
    logic [SLOT_COUNT-1:0]  link_vld_reg;
    logic [HANDLE_REGS-1:0] hnd_vld_reg;

    in_word_t            in_reg;
    logic [SLOT_W-1:0]   free_head_reg;
    logic                free_valid_reg;
    logic [CNT_W-1:0]    alloc_count_reg;
    logic [FOLD_W-1:0]   fold_acc_reg;
    logic [FOLD_W-1:0]   acc31_reg;
    logic [FOLD_W-1:0]   fold31_reg;

    logic [HND_W-1:0]    hnd_rd_reg;
    logic                hnd_vld_rd_reg;
    logic [SLOT_W-1:0]   slot_addr_reg;
    logic [DATA_W-1:0]   data_rd_reg;
    logic [GEN_W-1:0]    gen_rd_reg;
    logic                gen_vld_rd_reg;
    logic [SLOT_W:0]     link_rd_reg;
    logic                link_vld_rd_reg;

    logic [VALUE_W-1:0]  value_reg;
    logic                rej_reg;
    logic                m_valid_reg;
    out_word_t           m_data_reg;

    logic [REG_W-1:0]    hreg_idx;
    logic [SLOT_W-1:0]   hnd_slot;
    logic [GEN_W-1:0]    hnd_gen;
    logic [SLOT_W-1:0]   slot_addr;
    logic [GEN_W-1:0]    gen_eff;
    logic [SLOT_W-1:0]   link_eff;
    logic                link_ok_eff;
    logic                is_alloc;
    logic                rej;
    logic [VALUE_W-1:0]  value_raw;
    logic [VALUE_W-1:0]  value_fin;
    logic                alloc_ok;
    logic                free_ok;
    logic                write_ok;
    logic                clr;

    assign hreg_idx  = reg_tab[in_reg.arg_byte];
    assign hnd_slot  = hnd_rd_reg[GEN_W +: SLOT_W];
    assign hnd_gen   = hnd_rd_reg[GEN_W-1:0];
    assign is_alloc  = (in_reg.mode == MODE_ALLOC);
    assign slot_addr = is_alloc ? free_head_reg : hnd_slot;
    assign clr       = cmd.accept && s_data.restart;

    // entries without a valid bit read as their reset value
    assign gen_eff     = gen_vld_rd_reg ? gen_rd_reg : '0;
    assign link_eff    = link_vld_rd_reg ? link_rd_reg[SLOT_W-1:0]
                                         : SLOT_W'(slot_addr_reg + 1'b1);
    assign link_ok_eff = link_vld_rd_reg ? link_rd_reg[SLOT_W]
                                         : (slot_addr_reg != LAST_SLOT);

    always_comb begin
        if (is_alloc) begin
            rej = !free_valid_reg;
        end else begin
            rej = !hnd_vld_rd_reg || (gen_eff != hnd_gen);
        end
        unique case (in_reg.mode)
            MODE_ALLOC: value_raw = VALUE_W'(slot_addr_reg)
                                  + VALUE_W'({gen_eff, {GEN_SHIFT{1'b0}}});
            MODE_FREE:  value_raw = FREE_VALUE;
            MODE_READ:  value_raw = VALUE_W'(data_rd_reg);
            MODE_WRITE: value_raw = WRITE_VALUE;
        endcase
        value_fin = rej ? REJECT_VALUE : value_raw;
    end

    assign alloc_ok = cmd.update && !rej && (in_reg.mode == MODE_ALLOC);
    assign free_ok  = cmd.update && !rej && (in_reg.mode == MODE_FREE);
    assign write_ok = cmd.update && !rej && (in_reg.mode == MODE_WRITE);

    // input word
    always_ff @(posedge aclk) begin
        if (cmd.accept) in_reg <= s_data;
    end

    // handle store
    always_ff @(posedge aclk) begin
        if (alloc_ok) handle_mem[hreg_idx] <= {slot_addr_reg, gen_eff};
        if (cmd.rd_handle) hnd_rd_reg <= handle_mem[hreg_idx];
    end

    // slot data store
    always_ff @(posedge aclk) begin
        if (alloc_ok) begin
            data_mem[slot_addr_reg] <= DATA_W'(in_reg.arg_byte * ALLOC_MUL + ALLOC_ADD);
        end else if (write_ok) begin
            data_mem[slot_addr_reg] <= DATA_W'(in_reg.arg_byte * WRITE_MUL + WRITE_ADD);
        end
        if (cmd.rd_slot) data_rd_reg <= data_mem[slot_addr];
    end

    // generation and link stores
    always_ff @(posedge aclk) begin
        if (free_ok) begin
            gen_mem[slot_addr_reg]  <= gen_eff + 1'b1;
            link_mem[slot_addr_reg] <= {free_valid_reg, free_head_reg};
        end
        if (cmd.rd_slot) begin
            gen_rd_reg  <= gen_mem[slot_addr];
            link_rd_reg <= link_mem[slot_addr];
        end
    end

    // read-side payload registers
    always_ff @(posedge aclk) begin
        if (cmd.rd_handle) begin
            hnd_vld_rd_reg <= hnd_vld_reg[hreg_idx];
            acc31_reg      <= (fold_acc_reg << FOLD_SHIFT) - fold_acc_reg;
        end
        if (cmd.rd_slot) begin
            slot_addr_reg   <= slot_addr;
            gen_vld_rd_reg  <= gen_vld_reg[slot_addr];
            link_vld_rd_reg <= link_vld_reg[slot_addr];
        end
        if (cmd.update) begin
            value_reg <= value_fin;
            rej_reg   <= rej;
        end
        if (cmd.mul) fold31_reg <= (fold_acc_reg << FOLD_SHIFT) - fold_acc_reg;
    end

    // pool control state, cleared by reset or by a restart word
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            gen_vld_reg     <= '0;
            link_vld_reg    <= '0;
            hnd_vld_reg     <= '0;
            free_head_reg   <= '0;
            free_valid_reg  <= 1'b1;
            alloc_count_reg <= '0;
            fold_acc_reg    <= '0;
        end else begin
            if (cmd.update) fold_acc_reg <= acc31_reg + FOLD_W'(value_fin);
            if (alloc_ok) begin
                hnd_vld_reg[hreg_idx] <= 1'b1;
                free_head_reg         <= link_eff;
                free_valid_reg        <= link_ok_eff;
                alloc_count_reg       <= alloc_count_reg + 1'b1;
            end
            if (free_ok) begin
                gen_vld_reg[slot_addr_reg]  <= 1'b1;
                link_vld_reg[slot_addr_reg] <= 1'b1;
                free_head_reg               <= slot_addr_reg;
                free_valid_reg              <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.result_value <= value_reg;
            m_data_reg.rejected     <= rej_reg;
            m_data_reg.running_fold <= fold_acc_reg;
            m_data_reg.digest       <= fold31_reg + FOLD_W'(alloc_count_reg);
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule
`default_nettype wire

### src/gcsp_checker.sv
// Port-level checks for the slot pool, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "generation_checked_slot_pool_defines.svh"
module gcsp_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input gcsp_pkg::out_word_t  m_data
);
    import gcsp_pkg::*;

    logic s_fire;
    logic m_stall;

    assign s_fire  = s_valid && s_ready;
    assign m_stall = m_valid && !m_ready;

    // a rejected word always carries the reject code
    `GCSP_ASSERT_NOW(a_reject_code, m_valid && m_data.rejected, m_data.result_value == REJECT_VALUE)
    // one word in flight: input closes right after an accept
    `GCSP_ASSERT_NEXT(a_one_in_flight, s_fire, !s_ready)
    // no result can appear the cycle after an accept into an empty output
    `GCSP_ASSERT_NEXT(a_min_latency, s_fire && !m_valid, !m_valid)
    // stalled result holds
    `GCSP_ASSERT_NEXT(a_out_hold, m_stall, m_valid && $stable(m_data))

endmodule

bind generation_checked_slot_pool gcsp_checker u_gcsp_checker (.*);
`default_nettype wire
